/* rtl/tods_pkg.sv */
// Shared types, constants and helpers for the time-of-day set table.
package tods_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int ENTRY_W     = HOUR_W + MIN_W;
  localparam int CHAR_W      = 8;

  // Character and range constants
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [6:0]        HOUR_MAX   = 7'd23;
  localparam logic [6:0]        MIN_MAX    = 7'd59;
  localparam logic [CNT_W-1:0]  MAX_ENTRIES_RST = 5'd16;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NO_COLON  = 4'd1,
    ST_NON_DIGIT = 4'd2,
    ST_RANGE     = 4'd3,
    ST_FULL      = 4'd4,
    ST_DUPLICATE = 4'd5,
    ST_EMPTY     = 4'd6,
    ST_NOT_FOUND = 4'd7,
    ST_BAD_INDEX = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_FINISH
  } state_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Two ASCII digits to a value 0..99
  function automatic logic [6:0] two_digits(input logic [CHAR_W-1:0] tens,
                                            input logic [CHAR_W-1:0] ones);
    logic [CHAR_W-1:0] t;
    logic [CHAR_W-1:0] o;
    t = tens - CHAR_ZERO;
    o = ones - CHAR_ZERO;
    return ({3'b000, t[3:0]} << 3) + ({3'b000, t[3:0]} << 1) + {3'b000, o[3:0]};
  endfunction

endpackage

/* rtl/tods_in_if.sv */
// Command channel: valid/ready handshake with the time text and mode.
interface tods_in_if;
  import tods_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [CHAR_W-1:0] hour_tens_char;
  logic [CHAR_W-1:0] hour_ones_char;
  logic [CHAR_W-1:0] separator_char;
  logic [CHAR_W-1:0] minute_tens_char;
  logic [CHAR_W-1:0] minute_ones_char;
  logic [IDX_W-1:0]  entry_index;

  modport source (
    output valid, mode, hour_tens_char, hour_ones_char, separator_char,
           minute_tens_char, minute_ones_char, entry_index,
    input  ready
  );

  modport sink (
    input  valid, mode, hour_tens_char, hour_ones_char, separator_char,
           minute_tens_char, minute_ones_char, entry_index,
    output ready
  );
endinterface

/* rtl/tods_out_if.sv */
// Result channel: valid/ready handshake with status, count and read data.
interface tods_out_if;
  import tods_pkg::*;

  logic              valid;
  logic              ready;
  logic [3:0]        status;
  logic [CNT_W-1:0]  entry_count;
  logic [HOUR_W-1:0] read_hour;
  logic [MIN_W-1:0]  read_minute;

  modport source (
    output valid, status, entry_count, read_hour, read_minute,
    input  ready
  );

  modport sink (
    input  valid, status, entry_count, read_hour, read_minute,
    output ready
  );
endinterface

/* rtl/time_of_day_set_table_top.sv */
// Time-of-day set table: command decode, scan/compaction sequencer and entry store.
//
// Each command beat is taken only while the sequencer is idle; one beat gives one
// result beat. Add and remove walk the stored entries one per cycle through a single
// read port and compare; an add that finds a duplicate at entry p stops there. A
// remove that hits entry p stops scanning there and shifts the tail down one entry
// per cycle. The input is ready again on the cycle the result appears. The finished
// result sits in an output register, so the next command is accepted while it waits;
// if that command finishes before the waiting result is taken, the sequencer holds
// until the register frees up. The max_entries register (reset 16) caps the fill
// level and is written with cfg_we.
module time_of_day_set_table_top
  import tods_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  tods_in_if.sink          in_ch,
  tods_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  status_t            status_r, status_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   max_entries_r;
  logic [ENTRY_W-1:0] key_r, key_nxt;
  logic [HOUR_W-1:0]  rd_hour_r, rd_hour_nxt;
  logic [MIN_W-1:0]   rd_min_r, rd_min_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;
  logic [HOUR_W-1:0]  out_hour_r, out_hour_nxt;
  logic [MIN_W-1:0]   out_min_r, out_min_nxt;

  logic [ENTRY_W-1:0] entries_r [TABLE_DEPTH];
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic               accept;
  logic [CNT_W-1:0]   limit;
  logic [6:0]         hour_val;
  logic [6:0]         min_val;
  status_t            parse_status;
  logic [ENTRY_W-1:0] parsed_key;

  assign accept = in_ch.valid && in_ch.ready;
  assign limit  = (max_entries_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                         : max_entries_r;

  // Check the time text: colon, digits, then ranges
  always_comb begin
    hour_val   = two_digits(in_ch.hour_tens_char, in_ch.hour_ones_char);
    min_val    = two_digits(in_ch.minute_tens_char, in_ch.minute_ones_char);
    parsed_key = {hour_val[HOUR_W-1:0], min_val[MIN_W-1:0]};
    if (in_ch.separator_char != CHAR_COLON) begin
      parse_status = ST_NO_COLON;
    end else if (!is_digit(in_ch.hour_tens_char) || !is_digit(in_ch.hour_ones_char) ||
                 !is_digit(in_ch.minute_tens_char) || !is_digit(in_ch.minute_ones_char)) begin
      parse_status = ST_NON_DIGIT;
    end else if (hour_val > HOUR_MAX || min_val > MIN_MAX) begin
      parse_status = ST_RANGE;
    end else begin
      parse_status = ST_OK;
    end
  end

  // Single read port: the shift pass looks one entry ahead
  assign mem_raddr = (state_r == S_SHIFT) ? ptr_r[IDX_W-1:0] + IDX_W'(1)
                                          : ptr_r[IDX_W-1:0];
  assign mem_rdata = entries_r[mem_raddr];

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    status_nxt     = status_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    rd_hour_nxt    = rd_hour_r;
    rd_min_nxt     = rd_min_r;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r[IDX_W-1:0];
    mem_wdata      = mem_rdata;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_hour_nxt   = out_hour_r;
    out_min_nxt    = out_min_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = mode_t'(in_ch.mode);
          key_nxt     = parsed_key;
          ptr_nxt     = '0;
          rd_hour_nxt = '0;
          rd_min_nxt  = '0;
          status_nxt  = ST_OK;
          state_nxt   = S_FINISH;
          case (mode_t'(in_ch.mode))
            MODE_ADD: begin
              if (parse_status != ST_OK) begin
                status_nxt = parse_status;
              end else if (count_r >= limit) begin
                status_nxt = ST_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (parse_status != ST_OK) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
            end
            MODE_READ: begin
              if ({1'b0, in_ch.entry_index} >= count_r) begin
                status_nxt = ST_BAD_INDEX;
              end else begin
                ptr_nxt   = {1'b0, in_ch.entry_index};
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
        end
      end

      // Walk the stored entries looking for the key
      S_SCAN: begin
        if (ptr_r == count_r) begin
          state_nxt = S_FINISH;
          if (mode_r == MODE_ADD) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[IDX_W-1:0];
            mem_wdata = key_r;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end else if (mem_rdata == key_r) begin
          if (mode_r == MODE_ADD) begin
            status_nxt = ST_DUPLICATE;
            state_nxt  = S_FINISH;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end

      // Close the gap: move each later entry down by one
      S_SHIFT: begin
        if (ptr_r + CNT_W'(1) < count_r) begin
          mem_we    = 1'b1;
          mem_waddr = ptr_r[IDX_W-1:0];
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_r + CNT_W'(1);
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_FINISH;
        end
      end

      S_READ: begin
        rd_hour_nxt = mem_rdata[ENTRY_W-1:MIN_W];
        rd_min_nxt  = mem_rdata[MIN_W-1:0];
        state_nxt   = S_FINISH;
      end

      // Hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_r;
          out_hour_nxt   = rd_hour_r;
          out_min_nxt    = rd_min_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_entries_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    status_r     <= status_nxt;
    ptr_r        <= ptr_nxt;
    key_r        <= key_nxt;
    rd_hour_r    <= rd_hour_nxt;
    rd_min_r     <= rd_min_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_hour_r   <= out_hour_nxt;
    out_min_r    <= out_min_nxt;
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries_r[mem_waddr] <= mem_wdata;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;
  assign out_ch.read_hour   = out_hour_r;
  assign out_ch.read_minute = out_min_r;

endmodule

/* rtl/tods_checker.sv */
// Port-level checks on the result channel of the time-of-day set table.
module tods_checker
  import tods_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        out_status,
  input logic [CNT_W-1:0]  out_entry_count,
  input logic [HOUR_W-1:0] out_read_hour,
  input logic [MIN_W-1:0]  out_read_minute
);

  // A result beat waits until taken
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before it was taken");

  // Count never exceeds the table depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Read data is zero unless the command succeeded
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_hour == '0 && out_read_minute == '0)
    else $error("read data on a failed command");

  // Status codes stay in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_BAD_INDEX)
    else $error("status code out of range");

  // Empty status only comes with a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0)
    else $error("empty status with nonzero count");

endmodule

bind time_of_day_set_table_top tods_checker u_tods_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_entry_count (out_ch.entry_count),
  .out_read_hour   (out_ch.read_hour),
  .out_read_minute (out_ch.read_minute)
);
